// ===== hw/rtl/teletext_vram_access_controller_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker of the teletext VRAM access unit
// ---------------------------------------------------------------------------
`ifndef TELETEXT_VRAM_ACCESS_CONTROLLER_UNIT_DEFINES_SVH
`define TELETEXT_VRAM_ACCESS_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TVAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define TVAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tvac_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvac_pkg
// Types, codes and helper functions of the teletext VRAM access unit.
// ---------------------------------------------------------------------------
package tvac_pkg;

  // page store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;

  // access modes (access_mode[7:5])
  localparam logic [2:0] MODE_WR_INC   = 3'b000;
  localparam logic [2:0] MODE_RD_INC   = 3'b001;
  localparam logic [2:0] MODE_WR       = 3'b010;
  localparam logic [2:0] MODE_RD       = 3'b011;
  localparam logic [2:0] MODE_WR_SLICE = 3'b100;
  localparam logic [2:0] MODE_RD_SLICE = 3'b101;

  // port B commands (written byte [7:5])
  localparam logic [2:0] CMD_BEGIN_ROW = 3'b000;
  localparam logic [2:0] CMD_LOAD_ROW  = 3'b001;
  localparam logic [2:0] CMD_LOAD_COL  = 3'b010;
  localparam logic [2:0] CMD_ADVANCE   = 3'b011;
  localparam logic [2:0] CMD_LOAD_MODE = 3'b100;

  // codes at or above this go to external character memory
  localparam logic [7:0] CODE_EXT_MIN = 8'hA0;
  localparam logic [7:0] LATCH_FILL   = 8'hFF;
  localparam logic [4:0] ROW_COUNT    = 5'd24;
  localparam logic [4:0] SLICE_COUNT  = 5'd10;

  typedef struct packed {
    logic       mode;
    logic       command;
    logic       register_b;
    logic [7:0] write_data;
    logic [7:0] ext_read_data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        ext_write_strobe;
    logic        ext_read_strobe;
    logic [19:0] ext_address;
    logic [7:0]  ext_write_data;
  } result_t;

  typedef struct packed {
    logic [5:0] col;
    logic [4:0] row;
  } cursor_t;

  // controller to datapath
  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
    logic              take;
    logic              commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } ctrl_status_t;

  // scrambled page store address of the cursor
  function automatic logic [ADDR_W-1:0] cursor_addr(input cursor_t c);
    logic [ADDR_W-1:0] a;
    if (c.row[4:3] == 2'b11) begin
      a = {2'b11, c.col[5:3], 2'b11, c.col[2:0]};
    end else if (c.col[5]) begin
      a = {2'b11, c.row[2:0], c.row[4:3], c.col[2:0]};
    end else begin
      a = {c.row, c.col[4:0]};
    end
    return a;
  endfunction

  // cursor step: column wraps at 40, 48, 56 and 64, row wraps at 24 and 32
  function automatic cursor_t cursor_advance(input cursor_t c);
    cursor_t    n;
    logic [6:0] c7;
    logic [4:0] r5;
    c7 = {1'b0, c.col} + 7'd1;
    r5 = c.row + 5'd1;
    n  = c;
    if (c7 == 7'd40 || c7 == 7'd48 || c7 == 7'd56 || c7 == 7'd64) begin
      n.col = '0;
      n.row = (r5 == ROW_COUNT) ? 5'd0 : r5;
    end else begin
      n.col = c7[5:0];
    end
    return n;
  endfunction

  // (slice + 1) mod 10 for any 4-bit slice value
  function automatic logic [3:0] slice_next(input logic [3:0] s);
    logic [4:0] t;
    t = {1'b0, s} + 5'd1;
    if (t >= SLICE_COUNT) begin
      t = t - SLICE_COUNT;
    end
    return t[3:0];
  endfunction

endpackage

// ===== hw/rtl/tvac_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvac_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tvac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tvac_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvac_ctrl
// Sequencer: page store clearing after reset, then fetch and commit per item.
// ---------------------------------------------------------------------------
module tvac_ctrl
  import tvac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd,
  output logic         item_stall
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] count;

  // state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      count <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          count <= count + 1'b1;
          if (count == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!status.out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // commands
  assign item_stall     = (state != ST_IDLE);
  assign cmd.clear      = (state == ST_CLEAR);
  assign cmd.clear_addr = count;
  assign cmd.take       = (state == ST_IDLE) && item_valid;
  assign cmd.commit     = (state == ST_EXEC) && !status.out_busy;

endmodule

// ===== hw/rtl/tvac_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvac_datapath
// Latches, cursor, mode register, page stores and the result register.
// ---------------------------------------------------------------------------
module tvac_datapath
  import tvac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  input  item_t        item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result
);

  item_t             it;
  logic [7:0]        latch_a, latch_a_next;
  logic [7:0]        latch_b, latch_b_next;
  cursor_t           cursor, cursor_next;
  logic [7:0]        access_mode, access_mode_next;
  result_t           res_next;
  logic              st_wr;
  logic [ADDR_W-1:0] addr;
  logic [15:0]       mem_rd;
  logic [7:0]        at, cd;
  logic              ext_ok;
  cursor_t           cursor_adv;
  logic [3:0]        slice_n;

  assign addr       = cursor_addr(cursor);
  assign at         = mem_rd[15:8];
  assign cd         = mem_rd[7:0];
  assign ext_ok     = (cd >= CODE_EXT_MIN);
  assign cursor_adv = cursor_advance(cursor);
  assign slice_n    = slice_next(access_mode[3:0]);

  // attribute in the upper byte, code in the lower byte
  tvac_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.clear | (cmd.commit & st_wr)),
    .waddr(cmd.clear ? cmd.clear_addr : addr),
    .wdata(cmd.clear ? 16'h0000 : {latch_a, it.write_data}),
    .re   (cmd.take),
    .raddr(addr),
    .rdata(mem_rd)
  );

  // item register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it <= item;
    end
  end

  // access decode
  always_comb begin
    latch_a_next     = latch_a;
    latch_b_next     = latch_b;
    cursor_next      = cursor;
    access_mode_next = access_mode;
    res_next         = '0;
    st_wr            = 1'b0;
    if (!it.mode) begin
      if (!it.register_b) begin
        latch_a_next = it.write_data;
      end else if (it.command) begin
        latch_b_next = it.write_data;
        unique case (it.write_data[7:5])
          CMD_BEGIN_ROW: begin
            cursor_next.col = '0;
            cursor_next.row = latch_a[4:0];
          end
          CMD_LOAD_ROW:  cursor_next.row = latch_a[4:0];
          CMD_LOAD_COL:  cursor_next.col = latch_a[5:0];
          CMD_ADVANCE:   cursor_next = cursor_adv;
          CMD_LOAD_MODE: access_mode_next = latch_a;
          default: ;
        endcase
      end else begin
        latch_b_next = it.write_data;
        unique case (access_mode[7:5])
          MODE_WR_INC: begin
            st_wr       = 1'b1;
            cursor_next = cursor_adv;
          end
          MODE_WR: st_wr = 1'b1;
          MODE_WR_SLICE: begin
            if (ext_ok) begin
              res_next.ext_write_strobe = 1'b1;
              res_next.ext_address      = {at, cd, access_mode[3:0]};
              res_next.ext_write_data   = latch_a;
            end
            access_mode_next = {access_mode[7:4], slice_n};
          end
          default: ;
        endcase
      end
    end else begin
      if (it.command) begin
        res_next.read_data = 8'h00;
      end else if (!it.register_b) begin
        res_next.read_data = latch_a;
      end else begin
        res_next.read_data = latch_b;
        unique case (access_mode[7:5])
          MODE_RD_INC: begin
            latch_a_next = at;
            latch_b_next = cd;
            cursor_next  = cursor_adv;
          end
          MODE_RD: begin
            latch_a_next = at;
            latch_b_next = cd;
          end
          MODE_RD_SLICE: begin
            latch_a_next = LATCH_FILL;
            latch_b_next = LATCH_FILL;
            if (ext_ok) begin
              res_next.ext_read_strobe = 1'b1;
              res_next.ext_address     = {at, cd, access_mode[3:0]};
              latch_a_next             = it.ext_read_data;
            end
            access_mode_next = {access_mode[7:4], slice_n};
          end
          default: ;
        endcase
      end
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      latch_a     <= '0;
      latch_b     <= '0;
      cursor      <= '0;
      access_mode <= '0;
    end else if (cmd.commit) begin
      latch_a     <= latch_a_next;
      latch_b     <= latch_b_next;
      cursor      <= cursor_next;
      access_mode <= access_mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= res_next;
    end
  end

  assign status.out_busy = result_valid & result_stall;

endmodule

// ===== hw/rtl/teletext_vram_access_controller_unit.sv =====
`timescale 1ns / 1ps
// Timing: the item is registered and the store read on the transfer edge; the
//   result is registered on the commit that follows, held off while a result stalls.
// Items are taken one at a time, with item_stall high until the commit, as the
//   single page store port pair reads the store in the transfer cycle and writes
//   it back in the commit cycle. Reset: synchronous; after reset a clearing pass
//   over all 1024 entries zeroes the page stores, with item_stall high until it ends.
// ---------------------------------------------------------------------------
// teletext_vram_access_controller_unit
// Host bus access controller: latches, cursor, mode and page stores.
// ---------------------------------------------------------------------------
module teletext_vram_access_controller_unit
  import tvac_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer
  tvac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .status    (status),
    .cmd       (cmd),
    .item_stall(item_stall)
  );

  // datapath
  tvac_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

// ===== hw/rtl/tvac_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvac_checker
// Port-level checks of the teletext VRAM access unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "teletext_vram_access_controller_unit_defines.svh"

module tvac_checker
  import tvac_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result holds
  `TVAC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // one item in flight: the cycle after a transfer is stalled
  `TVAC_ASSERT_NEXT(a_one_in_flight, item_valid && !item_stall, item_stall, "item taken while busy")

  // never both external strobes
  `TVAC_ASSERT_NOW(a_strobe_excl, result_valid, !(result.ext_write_strobe && result.ext_read_strobe), "both strobes set")

  // no strobe, no external address
  `TVAC_ASSERT_NOW(a_addr_idle, result_valid && !result.ext_write_strobe && !result.ext_read_strobe, result.ext_address == 20'd0, "address without strobe")

  // a write slice is a write: nothing read back
  `TVAC_ASSERT_NOW(a_wr_no_rd, result_valid && result.ext_write_strobe, result.read_data == 8'd0, "read data on a write slice")

endmodule

bind teletext_vram_access_controller_unit tvac_checker u_checker (.*);

// ===== verif/vram_access_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vram_access_checker
// Watches the access and result channels of the VRAM access unit. It keeps
// its own latches, cursor, mode byte and page stores, works out the result of
// every access transfer, and compares each result transfer with the oldest
// prediction still waiting.
// ---------------------------------------------------------------------------
module vram_access_checker
  import tvac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  output int unsigned fail_count,
  output int unsigned pending
);

  // predicted unit state
  logic [7:0] latch_a_q;
  logic [7:0] latch_b_q;
  logic [5:0] col_q;
  logic [4:0] row_q;
  logic [7:0] page_mode;
  logic [7:0] attr_page [0:STORE_DEPTH-1];
  logic [7:0] code_page [0:STORE_DEPTH-1];

  result_t expected_q [$];

  // cursor step: column wraps at 40, 48, 56 and 64, row wraps past 23 and 31
  task automatic step_cursor();
    int unsigned nc;
    nc = col_q + 1;
    if (nc >= 40 && nc % 8 == 0) begin
      col_q = '0;
      row_q = (row_q == ROW_COUNT - 5'd1 || row_q == 5'd31) ? 5'd0 : row_q + 5'd1;
    end else begin
      col_q = nc[5:0];
    end
  endtask

  // slice number counts modulo ten, from any four-bit start value
  task automatic bump_slice();
    int unsigned s;
    s = (page_mode[3:0] + 1) % SLICE_COUNT;
    page_mode[3:0] = s[3:0];
  endtask

  // one bus access: update the predicted state and form its result
  task automatic predict_access(input item_t acc, output result_t res);
    int unsigned       c;
    int unsigned       r;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        at;
    logic [7:0]        cd;
    c = 32'(col_q);
    r = 32'(row_q);
    // scrambled page address of the cursor
    if (r >= ROW_COUNT) begin
      idx = ADDR_W'('h318 | ((c & 'h38) << 2) | (c & 'h7));
    end else if (c >= 32) begin
      idx = ADDR_W'('h300 | ((r & 'h7) << 5) | (r & 'h18) | (c & 'h7));
    end else begin
      idx = ADDR_W'((r << 5) | (c & 'h1F));
    end
    at  = attr_page[idx];
    cd  = code_page[idx];
    res = '0;

    if (!acc.mode) begin
      // bus write
      if (!acc.register_b) begin
        latch_a_q = acc.write_data;
      end else if (acc.command) begin
        latch_b_q = acc.write_data;
        case (acc.write_data[7:5])
          CMD_BEGIN_ROW: begin
            col_q = '0;
            row_q = latch_a_q[4:0];
          end
          CMD_LOAD_ROW:  row_q = latch_a_q[4:0];
          CMD_LOAD_COL:  col_q = latch_a_q[5:0];
          CMD_ADVANCE:   step_cursor();
          CMD_LOAD_MODE: page_mode = latch_a_q;
          default: ;  // display-only commands
        endcase
      end else begin
        latch_b_q = acc.write_data;
        case (page_mode[7:5])
          MODE_WR_INC, MODE_WR: begin
            attr_page[idx] = latch_a_q;
            code_page[idx] = latch_b_q;
            if (page_mode[7:5] == MODE_WR_INC) step_cursor();
          end
          MODE_WR_SLICE: begin
            if (cd >= CODE_EXT_MIN) begin
              res.ext_write_strobe = 1'b1;
              res.ext_address      = {at, cd, page_mode[3:0]};
              res.ext_write_data   = latch_a_q;
            end
            bump_slice();
          end
          default: ;
        endcase
      end
    end else if (acc.command) begin
      // status read, never busy
      res.read_data = '0;
    end else if (!acc.register_b) begin
      res.read_data = latch_a_q;
    end else begin
      // data port B read returns latch B as it stood before the access
      res.read_data = latch_b_q;
      case (page_mode[7:5])
        MODE_RD_INC, MODE_RD: begin
          latch_a_q = at;
          latch_b_q = cd;
          if (page_mode[7:5] == MODE_RD_INC) step_cursor();
        end
        MODE_RD_SLICE: begin
          latch_a_q = LATCH_FILL;
          latch_b_q = LATCH_FILL;
          if (cd >= CODE_EXT_MIN) begin
            res.ext_read_strobe = 1'b1;
            res.ext_address     = {at, cd, page_mode[3:0]};
            latch_a_q           = acc.ext_read_data;
          end
          bump_slice();
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  // compare result transfers, then predict the access transfer of this edge
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      latch_a_q = '0;
      latch_b_q = '0;
      col_q     = '0;
      row_q     = '0;
      page_mode = '0;
      attr_page = '{default: '0};
      code_page = '{default: '0};
      expected_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $error("result transfer with no access outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("read_data", 20'(want.read_data), 20'(result.read_data));
          check_field("ext_write_strobe", 20'(want.ext_write_strobe),
                      20'(result.ext_write_strobe));
          check_field("ext_read_strobe", 20'(want.ext_read_strobe),
                      20'(result.ext_read_strobe));
          check_field("ext_address", want.ext_address, result.ext_address);
          check_field("ext_write_data", 20'(want.ext_write_data),
                      20'(result.ext_write_data));
        end
      end
      if (item_valid && !item_stall) begin
        predict_access(item, want);
        expected_q.push_back(want);
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives bus accesses into the VRAM access unit: a short directed run over
// cursor wraps, every command, the store and read-advance access modes and both
// slice paths, then random command sequences and data bursts with random gaps on
// both channels. The checker beside the unit predicts and compares; this module
// gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
  import tvac_pkg::*;

  localparam logic BUS_WRITE = 1'b0;
  localparam logic BUS_READ  = 1'b1;
  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CMD  = 1'b1;
  localparam logic SEL_A     = 1'b0;
  localparam logic SEL_B     = 1'b1;
  localparam logic [2:0] CMD_DISPLAY_ONLY = 3'b111;
  localparam int unsigned RANDOM_ACCESSES = 1500;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       access_item;
  logic        result_valid;
  logic        result_stall;
  result_t     access_result;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned accesses_sent;
  bit          calm;

  teletext_vram_access_controller_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (access_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (access_result)
  );

  vram_access_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (access_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (access_result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random byte and random bit
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // stretches where neither side idles
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(200, 800)) @(posedge clk);
      calm = 1'b1;
      repeat ($urandom_range(30, 150)) @(posedge clk);
      calm = 1'b0;
    end
  end

  // result back-pressure
  initial begin : result_backpressure
    int unsigned n;
    result_stall = 1'b0;
    forever begin
      n = calm ? 0 : gap_len();
      @(negedge clk);
      result_stall <= (n != 0);
      if (n > 1) repeat (n - 1) @(negedge clk);
    end
  end

  // one access transfer, followed by a random idle gap
  task automatic bus_access(input logic rd, input logic cmd, input logic port_b,
                            input logic [7:0] wdata, input logic [7:0] xdata);
    int unsigned gap;
    @(negedge clk);
    item_valid  <= 1'b1;
    access_item <= {rd, cmd, port_b, wdata, xdata};
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    accesses_sent++;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  rnd;
    logic [7:0]  wdata;
    logic [2:0]  code;
    int unsigned kind;
    int unsigned n;
    int unsigned row_pick;
    int unsigned col_pick;
    int unsigned target;
    rst           = 1'b1;
    item_valid    = 1'b0;
    access_item   = '0;
    accesses_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: latch A extremes and read-back
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, 8'hFF, rnd_byte());
    bus_access(BUS_READ, PORT_DATA, SEL_A, rnd_byte(), rnd_byte());
    // cursor to row 23, column 39 (last visible cell)
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, 8'h97, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_BEGIN_ROW, 5'h00}, rnd_byte());
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, 8'h27, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_COL, 5'h1F}, rnd_byte());
    // store without advance, slice field above nine
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, {MODE_WR, 5'h1A}, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_MODE, 5'h00}, rnd_byte());
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, 8'hC5, rnd_byte());
    bus_access(BUS_WRITE, PORT_DATA, SEL_B, 8'hB3, rnd_byte());
    // read slice from slice 15, code above the external threshold
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, {MODE_RD_SLICE, 5'h0F}, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_MODE, 5'h1F}, rnd_byte());
    bus_access(BUS_READ, PORT_DATA, SEL_B, rnd_byte(), 8'h00);
    bus_access(BUS_READ, PORT_DATA, SEL_B, rnd_byte(), 8'hFF);
    // write slice from slice 9, wraps to 0
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, {MODE_WR_SLICE, 5'h09}, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_MODE, 5'h05}, rnd_byte());
    bus_access(BUS_WRITE, PORT_DATA, SEL_B, 8'h00, rnd_byte());
    // read with advance: column 40 wraps, row 24 goes back to 0
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, {MODE_RD_INC, 5'h00}, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_MODE, 5'h00}, rnd_byte());
    bus_access(BUS_READ, PORT_DATA, SEL_B, rnd_byte(), rnd_byte());
    // status reads
    bus_access(BUS_READ, PORT_CMD, SEL_A, rnd_byte(), rnd_byte());
    bus_access(BUS_READ, PORT_CMD, SEL_B, rnd_byte(), rnd_byte());
    // out-of-range cursor row 31, column 63, then advance past both
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, 8'h1F, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_ROW, 5'h00}, rnd_byte());
    bus_access(BUS_WRITE, PORT_DATA, SEL_A, 8'h3F, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_COL, 5'h00}, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_ADVANCE, 5'h00}, rnd_byte());
    bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_DISPLAY_ONLY, 5'h15}, rnd_byte());

    // random: mostly set-up sequences and data bursts in a small page area
    target = accesses_sent + RANDOM_ACCESSES;
    while (accesses_sent < target) begin
      kind = $urandom_range(0, 19);
      rnd  = rnd_byte();
      if (kind < 3) begin
        // place the cursor
        row_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 1);
        col_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
        bus_access(BUS_WRITE, rnd_bit(), SEL_A,
                   {rnd[7:5], row_pick[4:0]}, rnd_byte());
        code = ($urandom_range(0, 1) != 0) ? CMD_BEGIN_ROW : CMD_LOAD_ROW;
        bus_access(BUS_WRITE, PORT_CMD, SEL_B, {code, rnd[4:0]}, rnd_byte());
        bus_access(BUS_WRITE, rnd_bit(), SEL_A,
                   {rnd[1:0], col_pick[5:0]}, rnd_byte());
        bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_COL, rnd[6:2]}, rnd_byte());
      end else if (kind < 5) begin
        // new access mode with any slice number
        code = 3'($urandom_range(0, 7));
        bus_access(BUS_WRITE, PORT_DATA, SEL_A, {code, rnd[4:0]}, rnd_byte());
        bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_LOAD_MODE, rnd[7:3]}, rnd_byte());
      end else if (kind < 16) begin
        // burst on data port B, codes often in the external range
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0)
            bus_access(BUS_WRITE, PORT_DATA, SEL_A, rnd_byte(), rnd_byte());
          wdata = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(160, 255)) : rnd_byte();
          bus_access(rnd_bit(), PORT_DATA, SEL_B, wdata, rnd_byte());
        end
      end else if (kind < 18) begin
        // cursor advance or any command byte
        if ($urandom_range(0, 1) != 0)
          bus_access(BUS_WRITE, PORT_CMD, SEL_B, {CMD_ADVANCE, rnd[4:0]}, rnd_byte());
        else
          bus_access(BUS_WRITE, PORT_CMD, SEL_B, rnd, rnd_byte());
      end else begin
        // noise
        n = $urandom_range(1, 4);
        repeat (n) begin
          bus_access(rnd_bit(), rnd_bit(), rnd_bit(), rnd_byte(), rnd_byte());
        end
      end
    end

    // drain
    @(negedge clk);
    item_valid <= 1'b0;
    n = 0;
    while (pending != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("teletext_vram_access_controller_unit test passed");
    end else begin
      $display("teletext_vram_access_controller_unit test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(20_000_000);
    $display("teletext_vram_access_controller_unit test failed");
    $finish;
  end

endmodule

// ===== teletext_vram_access_controller_unit.f =====
+incdir+hw/rtl
hw/rtl/tvac_pkg.sv
hw/rtl/tvac_ram.sv
hw/rtl/tvac_ctrl.sv
hw/rtl/tvac_datapath.sv
hw/rtl/teletext_vram_access_controller_unit.sv
hw/rtl/tvac_checker.sv
verif/vram_access_checker.sv
verif/testbench.sv
